/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk outside reset.
`define BRBO_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BRBO_ASSERT_NEXT(label, cond, prop, msg) \
	`BRBO_ASSERT(label, (cond) |=> (prop), msg)

`endif

/* rtl/core/brbo_pkg.sv */
// ----------------------------------------------------------------------------
// Byte ring buffer package
// Command types and fixed widths shared by the ring buffer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brbo_pkg;

	// Must be a power of two no larger than 64, so that offsets and lengths fit.
	localparam int DEPTH       = 64;
	localparam int DATA_W      = 8;
	localparam int COUNT_W     = 7;
	localparam int OFF_W       = 6;
	localparam int LEN_W       = 7;
	localparam int READ_LIMIT  = 64;
	// Must be a power of two.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_PEEK   = 2'd2,
		OP_COMMIT = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} cmd_t;

endpackage

/* rtl/core/brbo_front.sv */
// ----------------------------------------------------------------------------
// Ring buffer front end
// Accepts requests, decodes the mode into a command and hands it to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbo_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [brbo_pkg::DATA_W-1:0]  data,
	input  logic [brbo_pkg::COUNT_W-1:0] count,
	output logic                         push,
	output brbo_pkg::cmd_t               cmd,
	input  logic                         q_full
);

	logic           valid_s1;
	brbo_pkg::cmd_t cmd_s1;
	brbo_pkg::op_t  op_dec;
	logic           load;

	always_comb begin
		case (mode)
			2'd0:    op_dec = brbo_pkg::OP_WRITE;
			2'd1:    op_dec = brbo_pkg::OP_READ;
			2'd2:    op_dec = brbo_pkg::OP_PEEK;
			2'd3:    op_dec = brbo_pkg::OP_COMMIT;
			default: op_dec = brbo_pkg::OP_WRITE;
		endcase
	end

	assign in_stall = valid_s1 && q_full;
	assign load     = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_s1.op    <= op_dec;
			cmd_s1.data  <= data;
			cmd_s1.count <= count;
		end
	end

endmodule

/* rtl/core/brbo_queue.sv */
// ----------------------------------------------------------------------------
// Ring buffer command queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbo_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  brbo_pkg::cmd_t push_cmd,
	output logic           full,
	output logic           q_valid,
	output brbo_pkg::cmd_t q_cmd,
	input  logic           pop
);

	localparam int QA = (brbo_pkg::QUEUE_DEPTH > 1) ? $clog2(brbo_pkg::QUEUE_DEPTH) : 1;

	brbo_pkg::cmd_t  entry_q [brbo_pkg::QUEUE_DEPTH];
	logic [QA-1:0]   wr_q;
	logic [QA-1:0]   rd_q;
	logic [QA:0]     cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == (QA+1)'(brbo_pkg::QUEUE_DEPTH));
	assign q_valid = (cnt_q != '0);
	assign q_cmd   = entry_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_cmd;
		end
	end

endmodule

/* rtl/core/brbo_back.sv */
// ----------------------------------------------------------------------------
// Ring buffer back end
// Owns the storage and pointers, executes commands and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbo_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  brbo_pkg::cmd_t               q_cmd,
	output logic                         q_pop,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brbo_pkg::DATA_W-1:0]  data_out,
	output logic                         byte_valid,
	output logic [brbo_pkg::OFF_W-1:0]   seg_offset,
	output logic [brbo_pkg::LEN_W-1:0]   seg_length,
	output logic [brbo_pkg::COUNT_W-1:0] total_count,
	output logic                         last
);

	localparam int AW = $clog2(brbo_pkg::DEPTH);
	localparam int PW = AW + 1;
	localparam int NW = (PW > brbo_pkg::COUNT_W) ? PW : brbo_pkg::COUNT_W;
	localparam int CW = brbo_pkg::COUNT_W;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_PEEK2 = 3'b100
	} state_t;

	state_t                      state_q, state_d;
	logic [brbo_pkg::DATA_W-1:0] mem [brbo_pkg::DEPTH];
	logic [PW-1:0]               wp_q, wp_d, rp_q, rp_d;
	logic [CW-1:0]               n_q, n_d, i_q, i_d, j_q, j_d, len2_q, len2_d;
	logic                        rd_pend_q, rd_pend_d;
	logic [brbo_pkg::DATA_W-1:0] rdata_q;

	logic                        out_valid_q;
	logic [brbo_pkg::DATA_W-1:0] data_out_q;
	logic                        byte_valid_q;
	logic [brbo_pkg::OFF_W-1:0]  seg_offset_q;
	logic [brbo_pkg::LEN_W-1:0]  seg_length_q;
	logic [CW-1:0]               total_count_q;
	logic                        last_q;

	logic [PW-1:0]               fill_raw, fill, first, rd_sum;
	logic [AW-1:0]               start;
	logic [NW-1:0]               fill_n, count_n, min_n;
	logic [CW-1:0]               n_calc;
	logic                        out_free, consume, issue, last_byte, mem_we;

	logic                        out_load;
	logic [brbo_pkg::DATA_W-1:0] res_data;
	logic                        res_bv;
	logic [brbo_pkg::OFF_W-1:0]  res_off;
	logic [brbo_pkg::LEN_W-1:0]  res_len;
	logic [CW-1:0]               res_total;
	logic                        res_last;

	assign fill_raw  = wp_q - rp_q;
	assign fill      = (fill_raw > PW'(brbo_pkg::DEPTH)) ? PW'(brbo_pkg::DEPTH) : fill_raw;
	assign start     = rp_q[AW-1:0];
	assign first     = PW'(brbo_pkg::DEPTH) - {1'b0, start};
	assign fill_n    = NW'(fill);
	assign count_n   = NW'(q_cmd.count);
	assign min_n     = (count_n < fill_n) ? count_n : fill_n;
	assign n_calc    = (min_n > NW'(brbo_pkg::READ_LIMIT)) ?
		CW'(brbo_pkg::READ_LIMIT) : min_n[CW-1:0];
	assign rd_sum    = rp_q + PW'(j_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign last_byte = (i_q + 1'b1 == n_q);

	always_comb begin
		state_d   = state_q;
		wp_d      = wp_q;
		rp_d      = rp_q;
		n_d       = n_q;
		i_d       = i_q;
		j_d       = j_q;
		len2_d    = len2_q;
		rd_pend_d = rd_pend_q;
		q_pop     = 1'b0;
		mem_we    = 1'b0;
		issue     = 1'b0;
		consume   = 1'b0;
		out_load  = 1'b0;
		res_data  = '0;
		res_bv    = 1'b0;
		res_off   = '0;
		res_len   = '0;
		res_total = '0;
		res_last  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					case (q_cmd.op)
						brbo_pkg::OP_WRITE: begin
							q_pop  = 1'b1;
							mem_we = 1'b1;
							wp_d   = wp_q + 1'b1;
							if (fill == PW'(brbo_pkg::DEPTH)) begin
								rp_d = rp_q + 1'b1;
							end
						end
						brbo_pkg::OP_COMMIT: begin
							q_pop = 1'b1;
							rp_d  = rp_q + min_n[PW-1:0];
						end
						brbo_pkg::OP_READ: begin
							if (n_calc == '0) begin
								if (out_free) begin
									q_pop    = 1'b1;
									out_load = 1'b1;
									res_last = 1'b1;
								end
							end else begin
								q_pop     = 1'b1;
								n_d       = n_calc;
								i_d       = '0;
								j_d       = '0;
								rd_pend_d = 1'b0;
								state_d   = ST_READ;
							end
						end
						brbo_pkg::OP_PEEK: begin
							if (out_free) begin
								q_pop    = 1'b1;
								out_load = 1'b1;
								if (fill == '0) begin
									res_last = 1'b1;
								end else if (fill <= first) begin
									res_off   = brbo_pkg::OFF_W'(start);
									res_len   = brbo_pkg::LEN_W'(fill);
									res_total = CW'(1);
									res_last  = 1'b1;
								end else begin
									res_off   = brbo_pkg::OFF_W'(start);
									res_len   = brbo_pkg::LEN_W'(first);
									res_total = CW'(2);
									len2_d    = CW'(fill - first);
									state_d   = ST_PEEK2;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				consume   = rd_pend_q && out_free;
				issue     = (j_q < n_q) && (!rd_pend_q || consume);
				rd_pend_d = issue || (rd_pend_q && !consume);
				if (issue) begin
					j_d = j_q + 1'b1;
				end
				if (consume) begin
					out_load  = 1'b1;
					res_data  = rdata_q;
					res_bv    = 1'b1;
					res_total = n_q;
					res_last  = last_byte;
					i_d       = i_q + 1'b1;
					if (last_byte) begin
						rp_d    = rp_q + PW'(n_q);
						state_d = ST_IDLE;
					end
				end
			end
			ST_PEEK2: begin
				if (out_free) begin
					out_load  = 1'b1;
					res_len   = len2_q;
					res_total = CW'(2);
					res_last  = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			len2_q      <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
			n_q       <= n_d;
			i_q       <= i_d;
			j_q       <= j_d;
			len2_q    <= len2_d;
			rd_pend_q <= rd_pend_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wp_q[AW-1:0]] <= q_cmd.data;
		end
		if (issue) begin
			rdata_q <= mem[rd_sum[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			data_out_q    <= res_data;
			byte_valid_q  <= res_bv;
			seg_offset_q  <= res_off;
			seg_length_q  <= res_len;
			total_count_q <= res_total;
			last_q        <= res_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign data_out    = data_out_q;
	assign byte_valid  = byte_valid_q;
	assign seg_offset  = seg_offset_q;
	assign seg_length  = seg_length_q;
	assign total_count = total_count_q;
	assign last        = last_q;

endmodule

/* rtl/core/byte_ring_buffer_overwrite.sv */
// Path: a peek or empty read passes the front-end register, the queue and the result
// register; a read also passes the registered storage read before its first byte shows.
// Throughput: writes and commits retire one per cycle while the back end is idle; a read
// streams one byte per cycle while out_stall is low; a peek sends one result per segment.
// Reset: arst_n clears both pointers, the queue and all valid flags at once; the storage
// is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Byte ring buffer with overwrite
// Power-of-two ring buffer of bytes that drops the oldest byte when full and
// supports read, peek and commit requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byte_ring_buffer_overwrite (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   mode,
	input  logic [brbo_pkg::DATA_W-1:0]  data,
	input  logic [brbo_pkg::COUNT_W-1:0] count,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [brbo_pkg::DATA_W-1:0]  data_out,
	output logic                         byte_valid,
	output logic [brbo_pkg::OFF_W-1:0]   seg_offset,
	output logic [brbo_pkg::LEN_W-1:0]   seg_length,
	output logic [brbo_pkg::COUNT_W-1:0] total_count,
	output logic                         last
);

	logic           push;
	logic           q_full;
	logic           q_valid;
	logic           q_pop;
	brbo_pkg::cmd_t front_cmd;
	brbo_pkg::cmd_t q_cmd;

	brbo_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.data     (data),
		.count    (count),
		.push     (push),
		.cmd      (front_cmd),
		.q_full   (q_full)
	);

	brbo_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.full     (q_full),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (q_pop)
	);

	brbo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.data_out    (data_out),
		.byte_valid  (byte_valid),
		.seg_offset  (seg_offset),
		.seg_length  (seg_length),
		.total_count (total_count),
		.last        (last)
	);

endmodule

/* rtl/core/brbo_checker.sv */
// ----------------------------------------------------------------------------
// Ring buffer port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brbo_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic                         byte_valid,
	input logic [brbo_pkg::OFF_W-1:0]   seg_offset,
	input logic [brbo_pkg::LEN_W-1:0]   seg_length,
	input logic [brbo_pkg::COUNT_W-1:0] total_count,
	input logic                         last
);

	logic out_acc;
	logic byte_ok;
	logic mid_byte;
	logic mid_peek;
	logic seg2_ok;

	assign out_acc  = out_valid && !out_stall;
	assign byte_ok  = (total_count != '0) && (seg_offset == '0) && (seg_length == '0);
	assign mid_byte = out_acc && byte_valid && !last;
	assign mid_peek = out_acc && !byte_valid && (total_count == brbo_pkg::COUNT_W'(2)) && !last;
	assign seg2_ok  = last && !byte_valid && (seg_offset == '0);

	`BRBO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped in stall")
	`BRBO_ASSERT(a_byte_fields, out_valid && byte_valid |-> byte_ok, "read byte fields wrong")
	`BRBO_ASSERT_NEXT(a_read_run, mid_byte, !out_valid || byte_valid, "read run broken")
	`BRBO_ASSERT_NEXT(a_run_total, mid_byte, $stable(total_count), "read total changed")
	`BRBO_ASSERT_NEXT(a_peek_second, mid_peek, !out_valid || seg2_ok, "second segment wrong")

endmodule

bind byte_ring_buffer_overwrite brbo_checker u_checker (.*);

/* sim/byte_ring_buffer_overwrite_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte ring buffer with overwrite testbench
// Drives write, read, peek and commit requests with random gaps and output
// stalls, predicts every result with an independent ring model, and compares
// each accepted result field by field in arrival order.
// ----------------------------------------------------------------------------

module byte_ring_buffer_overwrite_tb;

	localparam int RING_DEPTH     = brbo_pkg::DEPTH;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int RANDOM_ITEMS   = 240;

	typedef struct packed {
		logic [brbo_pkg::DATA_W-1:0]  data_out;
		logic                         byte_valid;
		logic [brbo_pkg::OFF_W-1:0]   seg_offset;
		logic [brbo_pkg::LEN_W-1:0]   seg_length;
		logic [brbo_pkg::COUNT_W-1:0] total_count;
		logic                         last;
	} result_t;

	class ring_scoreboard;
		logic [brbo_pkg::DATA_W-1:0] mem [RING_DEPTH];
		logic [6:0]                  rd_ptr;
		logic [6:0]                  wr_ptr;
		result_t                     pending [$];
		int                          errors;
		int                          n_requests;
		int                          n_results;
		int                          op_hits [4];
		int                          overwrites;
		int                          split_peeks;
		int                          longest_read;

		function new();
			rd_ptr = '0;
			wr_ptr = '0;
			errors = 0;
			n_requests = 0;
			n_results = 0;
			overwrites = 0;
			split_peeks = 0;
			longest_read = 0;
			foreach (op_hits[i]) op_hits[i] = 0;
		endfunction

		function logic [6:0] fill_level();
			logic [6:0] f;
			f = wr_ptr - rd_ptr;
			if (f > 7'(RING_DEPTH)) f = 7'(RING_DEPTH);
			return f;
		endfunction

		function result_t make_result(logic [7:0] dout, logic valid, logic [5:0] off,
				logic [6:0] len, logic [6:0] total, logic lst);
			return {dout, valid, off, len, total, lst};
		endfunction

		function void note_request(brbo_pkg::op_t op, logic [brbo_pkg::DATA_W-1:0] d,
				logic [brbo_pkg::COUNT_W-1:0] c);
			logic [6:0] fill;
			logic [6:0] n;
			logic [6:0] first;
			logic [5:0] start;
			logic [5:0] slot;
			fill = fill_level();
			n_requests++;
			op_hits[op]++;
			case (op)
				brbo_pkg::OP_WRITE: begin
					if (fill >= 7'(RING_DEPTH)) begin
						rd_ptr = rd_ptr + 7'd1;
						overwrites++;
					end
					mem[wr_ptr[5:0]] = d;
					wr_ptr = wr_ptr + 7'd1;
				end
				brbo_pkg::OP_READ: begin
					n = c;
					if (n > fill) n = fill;
					if (n > 7'(brbo_pkg::READ_LIMIT)) n = 7'(brbo_pkg::READ_LIMIT);
					if (n == 0) begin
						pending.push_back(make_result('0, 1'b0, '0, '0, '0, 1'b1));
					end else begin
						for (int i = 0; i < int'(n); i++) begin
							slot = rd_ptr[5:0] + 6'(i);
							pending.push_back(make_result(mem[slot], 1'b1, '0, '0, n,
								(i == int'(n) - 1)));
						end
						rd_ptr = rd_ptr + n;
						if (int'(n) > longest_read) longest_read = int'(n);
					end
				end
				brbo_pkg::OP_PEEK: begin
					start = rd_ptr[5:0];
					first = 7'd64 - {1'b0, start};
					if (fill == 0) begin
						pending.push_back(make_result('0, 1'b0, '0, '0, '0, 1'b1));
					end else if (fill <= first) begin
						pending.push_back(make_result('0, 1'b0, start, fill, 7'd1, 1'b1));
					end else begin
						pending.push_back(make_result('0, 1'b0, start, first, 7'd2, 1'b0));
						pending.push_back(make_result('0, 1'b0, '0, fill - first, 7'd2, 1'b1));
						split_peeks++;
					end
				end
				default: begin
					n = (c > fill) ? fill : c;
					rd_ptr = rd_ptr + n;
				end
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
					n_results, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			n_results++;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					n_results));
				return;
			end
			want = pending.pop_front();
			check_field("data_out", got.data_out, want.data_out);
			check_field("byte_valid", 8'(got.byte_valid), 8'(want.byte_valid));
			check_field("seg_offset", 8'(got.seg_offset), 8'(want.seg_offset));
			check_field("seg_length", 8'(got.seg_length), 8'(want.seg_length));
			check_field("total_count", 8'(got.total_count), 8'(want.total_count));
			check_field("last", 8'(got.last), 8'(want.last));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_stall;
	logic [1:0]                   mode = 2'd0;
	logic [brbo_pkg::DATA_W-1:0]  data = '0;
	logic [brbo_pkg::COUNT_W-1:0] count = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [brbo_pkg::DATA_W-1:0]  data_out;
	logic                         byte_valid;
	logic [brbo_pkg::OFF_W-1:0]   seg_offset;
	logic [brbo_pkg::LEN_W-1:0]   seg_length;
	logic [brbo_pkg::COUNT_W-1:0] total_count;
	logic                         last;

	ring_scoreboard sb = new();
	bit             in_burst = 1'b0;
	bit             out_burst = 1'b0;
	int             idle_cycles = 0;

	byte_ring_buffer_overwrite dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.data(data),
		.count(count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out(data_out),
		.byte_valid(byte_valid),
		.seg_offset(seg_offset),
		.seg_length(seg_length),
		.total_count(total_count),
		.last(last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({data_out, byte_valid, seg_offset, seg_length, total_count, last});
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding.", sb.pending.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int w;
		forever begin
			w = out_burst ? 0 : $urandom_range(0, 19);
			@(negedge clk);
			out_stall <= (w != 0);
			if (w != 0) begin
				repeat (w) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	function automatic logic [brbo_pkg::COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 3))
			0: return 7'($urandom_range(0, 3));
			1: return 7'($urandom_range(0, 64));
			2: return 7'd64;
			default: return 7'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic send_req(brbo_pkg::op_t op, logic [brbo_pkg::DATA_W-1:0] d,
			logic [brbo_pkg::COUNT_W-1:0] c);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		data <= d;
		count <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(op, d, c);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic flood_fill(int n, logic [brbo_pkg::COUNT_W-1:0] read_len);
		repeat (n) send_req(brbo_pkg::OP_WRITE, 8'($urandom), pick_count());
		send_req(brbo_pkg::OP_PEEK, 8'($urandom), pick_count());
		send_req(brbo_pkg::OP_READ, 8'($urandom), read_len);
	endtask

	initial begin
		int target;
		int kind;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_req(brbo_pkg::OP_READ, 8'h00, 7'd5);
		send_req(brbo_pkg::OP_READ, 8'hFF, 7'd0);
		send_req(brbo_pkg::OP_PEEK, 8'hFF, 7'd64);
		send_req(brbo_pkg::OP_COMMIT, 8'h00, 7'd64);
		send_req(brbo_pkg::OP_WRITE, 8'h00, 7'd0);
		send_req(brbo_pkg::OP_WRITE, 8'hFF, 7'd64);
		send_req(brbo_pkg::OP_WRITE, 8'hA5, 7'd1);
		send_req(brbo_pkg::OP_WRITE, 8'h5A, 7'd0);
		send_req(brbo_pkg::OP_WRITE, 8'h80, 7'd0);
		send_req(brbo_pkg::OP_PEEK, 8'h00, 7'd0);
		send_req(brbo_pkg::OP_READ, 8'h00, 7'd0);
		send_req(brbo_pkg::OP_READ, 8'h00, 7'd2);
		send_req(brbo_pkg::OP_COMMIT, 8'hFF, 7'd1);
		send_req(brbo_pkg::OP_PEEK, 8'h00, 7'd0);
		send_req(brbo_pkg::OP_READ, 8'h00, 7'd64);
		send_req(brbo_pkg::OP_WRITE, 8'h01, 7'd0);
		send_req(brbo_pkg::OP_WRITE, 8'h7F, 7'd0);
		send_req(brbo_pkg::OP_COMMIT, 8'h00, 7'd64);
		send_req(brbo_pkg::OP_PEEK, 8'h00, 7'd0);
		send_req(brbo_pkg::OP_COMMIT, 8'h00, 7'd3);
		wait_drained();

		target = sb.n_requests + RANDOM_ITEMS;
		flood_fill(70, 7'd64);
		while (sb.n_requests < target) begin
			in_burst = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 6) begin
				flood_fill($urandom_range(64, 72), 7'($urandom_range(48, 64)));
			end else if (kind < 65) begin
				repeat ($urandom_range(1, 12))
					send_req(brbo_pkg::OP_WRITE, 8'($urandom), pick_count());
				send_req(brbo_pkg::op_t'($urandom_range(1, 3)), 8'($urandom), pick_count());
				if ($urandom_range(0, 2) == 0)
					send_req(brbo_pkg::op_t'($urandom_range(1, 3)), 8'($urandom),
						pick_count());
			end else begin
				send_req(brbo_pkg::op_t'($urandom_range(0, 3)), 8'($urandom), pick_count());
			end
			if ($urandom_range(0, 19) == 0) wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report_mismatch($sformatf("%0d expected results never arrived",
				sb.pending.size()));
		$display("Covered %0d requests (%0d writes, %0d reads, %0d peeks, %0d commits).",
			sb.n_requests, sb.op_hits[brbo_pkg::OP_WRITE], sb.op_hits[brbo_pkg::OP_READ],
			sb.op_hits[brbo_pkg::OP_PEEK], sb.op_hits[brbo_pkg::OP_COMMIT]);
		$display("%0d results, %0d overwrites, %0d two-segment peeks, longest read %0d.",
			sb.n_results, sb.overwrites, sb.split_peeks, sb.longest_read);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
